[design/slwmn_pkg.sv]
// Shared types, constants and the prior mean table of the sliding window mean normaliser.
package slwmn_pkg;

    localparam int DIM        = 30;  // coefficients per frame
    localparam int POS_W      = 5;   // coefficient index width
    localparam int SUM_BITS   = 27;  // per-coefficient window sum
    localparam int STAT_BITS  = 28;  // statistic before division
    localparam int NUM_BITS   = 28;  // dividend width, |stat| plus half divisor
    localparam int DEN_BITS   = 11;  // divisor count width
    localparam int WF_BITS    = 11;  // window_frames register
    localparam int PF_BITS    = 10;  // prior_frames register
    localparam int PRIOR_W    = 16;  // prior mean, Q7.8
    localparam int APB_DW     = 32;
    localparam int APB_AW     = 3;

    localparam logic [WF_BITS-1:0]  RST_WINDOW_FRAMES = 11'd600;
    localparam logic [PF_BITS-1:0]  RST_PRIOR_FRAMES  = 10'd200;
    localparam logic [DEN_BITS-1:0] RST_DIVISOR       = 11'd201;

    // register indexes (byte address / 4)
    localparam logic REG_WINDOW_FRAMES = 1'b0;
    localparam logic REG_PRIOR_FRAMES  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SLOT,
        ST_ADDR,
        ST_MEM,
        ST_SUM,
        ST_STAT,
        ST_NUM,
        ST_DIV,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic                start;
        logic [NUM_BITS-1:0] num;
        logic [DEN_BITS-1:0] den;
    } t_div_req;

    // fixed global prior mean per coefficient, Q7.8
    function automatic logic signed [PRIOR_W-1:0] prior_mean(input logic [POS_W-1:0] pos);
        logic signed [PRIOR_W-1:0] m;
        case (pos)
            5'd0:    m = 16'sd4685;
            5'd1:    m = -16'sd2895;
            5'd2:    m = -16'sd1451;
            5'd3:    m = -16'sd1985;
            5'd4:    m = -16'sd4423;
            5'd5:    m = -16'sd3304;
            5'd6:    m = -16'sd4002;
            5'd7:    m = -16'sd3168;
            5'd8:    m = -16'sd2468;
            5'd9:    m = -16'sd2432;
            5'd10:   m = -16'sd2118;
            5'd11:   m = -16'sd2383;
            5'd12:   m = -16'sd1763;
            5'd13:   m = -16'sd1560;
            5'd14:   m = -16'sd1761;
            5'd15:   m = -16'sd1016;
            5'd16:   m = -16'sd855;
            5'd17:   m = -16'sd317;
            5'd18:   m = -16'sd392;
            5'd19:   m = -16'sd75;
            5'd20:   m = -16'sd87;
            5'd21:   m = -16'sd16;
            5'd22:   m = -16'sd9;
            5'd23:   m = 16'sd4;
            5'd24:   m = 16'sd17;
            5'd25:   m = 16'sd15;
            5'd26:   m = 16'sd33;
            5'd27:   m = 16'sd29;
            5'd28:   m = 16'sd59;
            5'd29:   m = 16'sd52;
            default: m = 16'sd0;
        endcase
        return m;
    endfunction

endpackage

[design/slwmn_div.sv]
// Restoring divider, one quotient bit per cycle.
module slwmn_div
    import slwmn_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_div_req            i_req,
    output logic                o_done,
    output logic [NUM_BITS-1:0] o_quo
);

    localparam int CNT_W = $clog2(NUM_BITS + 1);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [DEN_BITS-1:0] r_den;
    logic [DEN_BITS-1:0] r_rem;
    logic [NUM_BITS-1:0] r_quo;

    logic [DEN_BITS:0]   n_trial;
    logic [DEN_BITS:0]   n_diff;
    logic                n_ge;

    assign n_trial = {r_rem, r_quo[NUM_BITS-1]};
    assign n_diff  = n_trial - {1'b0, r_den};
    assign n_ge    = n_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_den <= i_req.den;
            r_rem <= '0;
            r_quo <= i_req.num;
        end else if (r_busy) begin
            r_rem <= n_ge ? n_diff[DEN_BITS-1:0] : n_trial[DEN_BITS-1:0];
            r_quo <= {r_quo[NUM_BITS-2:0], n_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

[design/slwmn_hist_ram.sv]
// Frame history memory: one write and one registered read port.
module slwmn_hist_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 30720,
    parameter int ADDR_W = 15
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [ADDR_W-1:0]        i_waddr,
    input  logic signed [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0]        i_raddr,
    output logic signed [DATA_W-1:0] o_rdata
);

    logic signed [DATA_W-1:0] r_mem [DEPTH];
    logic signed [DATA_W-1:0] r_rdata;

    // read before write on a shared address
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rdata        <= r_mem[i_raddr];
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/sliding_window_mean_normalizer_unit.sv]
// Top level of the sliding window mean normaliser: sequencer, counters, sums and output word.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------
//  input    | i_in_valid / o_in_stall    | i_sample_value (signed Q7.8)
//  output   | o_out_valid / i_out_stall  | o_norm_value (signed Q7.8), o_frame_end
//  config   | psel penable pwrite pready | paddr (3 bit), pwdata, prdata (32 bit)
//
// One word passes from acceptance through six set-up steps (SLOT, ADDR,
// MEM, SUM, STAT, NUM), then the restoring divider (one quotient bit per
// step, NUM_BITS wide) with its done flag, and the finish step, which
// waits while the output side is stalled.
// Synchronous active-low reset clears counters, window sums and the output valid;
// the frame history needs no clearing, a slot is only used once it was written.
// A stalled output word holds; the next input word is processed meanwhile and
// only waits at the final step until the output register is free.
module sliding_window_mean_normalizer_unit
    import slwmn_pkg::*;
#(
    parameter int MAX_WINDOW  = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input words
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_value,
    // output words
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [SAMPLE_BITS-1:0] o_norm_value,
    output logic                          o_frame_end,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [APB_AW-1:0]             paddr,
    input  logic [APB_DW-1:0]             pwdata,
    output logic [APB_DW-1:0]             prdata,
    output logic                          pready
);

    localparam int WIN_W  = $clog2(MAX_WINDOW + 1);       // 0..MAX_WINDOW
    localparam int SLOT_W = $clog2(MAX_WINDOW);           // ring slot
    localparam int ADDR_W = $clog2(MAX_WINDOW * DIM);     // history address
    localparam int CMP_W  = (WIN_W > WF_BITS) ? WIN_W : WF_BITS;
    localparam int OS_W   = WIN_W + 1;
    localparam int YW     = NUM_BITS + 2;                 // x -/+ quotient
    localparam logic signed [YW-1:0] Y_MAX = YW'(2 ** (SAMPLE_BITS - 1) - 1);
    localparam logic signed [YW-1:0] Y_MIN = -Y_MAX - YW'(1);

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [WF_BITS-1:0] r_window_frames;
    logic [PF_BITS-1:0] r_prior_frames;
    logic               cfg_wr;
    logic               cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_frames <= RST_WINDOW_FRAMES;
            r_prior_frames  <= RST_PRIOR_FRAMES;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_WINDOW_FRAMES: r_window_frames <= pwdata[WF_BITS-1:0];
                REG_PRIOR_FRAMES:  r_prior_frames  <= pwdata[PF_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_WINDOW_FRAMES: prdata = APB_DW'(r_window_frames);
            REG_PRIOR_FRAMES:  prdata = APB_DW'(r_prior_frames);
            default:           prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    t_state r_state;
    t_state n_state;
    logic   in_acc;
    logic   mem_en;
    logic   out_load;
    logic   div_done;
    t_div_req div_req;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_in_valid) n_state = ST_SLOT;
            ST_SLOT: n_state = ST_ADDR;
            ST_ADDR: n_state = ST_MEM;
            ST_MEM:  n_state = ST_SUM;
            ST_SUM:  n_state = ST_STAT;
            ST_STAT: n_state = ST_NUM;
            ST_NUM:  n_state = ST_DIV;
            ST_DIV:  if (div_done) n_state = ST_FIN;
            ST_FIN:  if (!o_out_valid || !i_out_stall) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        mem_en     = 1'b0;
        out_load   = 1'b0;
        case (r_state)
            ST_IDLE: o_in_stall = 1'b0;
            ST_MEM:  mem_en     = 1'b1;
            ST_FIN:  out_load   = !o_out_valid || !i_out_stall;
            default: ;
        endcase
    end

    assign in_acc = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    // ---------------------------------------------------------------
    // frame counters
    // ---------------------------------------------------------------
    logic [WIN_W-1:0]    r_frames_seen;   // saturates at MAX_WINDOW
    logic [SLOT_W-1:0]   r_ring_slot;
    logic [WF_BITS-1:0]  r_filled;
    logic [DEN_BITS-1:0] r_divisor;
    logic [POS_W-1:0]    r_coeff_pos;
    logic [WIN_W-1:0]    r_w;             // effective window of this word
    logic                last_c;

    logic [CMP_W-1:0]    wf_cmp;
    logic [CMP_W-1:0]    w_clamp;

    assign wf_cmp  = CMP_W'(r_window_frames);
    assign w_clamp = (wf_cmp == '0) ? CMP_W'(1) :
                     (wf_cmp > CMP_W'(MAX_WINDOW)) ? CMP_W'(MAX_WINDOW) : wf_cmp;
    assign last_c  = (r_coeff_pos == POS_W'(DIM - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_seen <= '0;
            r_ring_slot   <= '0;
            r_filled      <= '0;
            r_divisor     <= RST_DIVISOR;
            r_coeff_pos   <= '0;
            r_w           <= WIN_W'(1);
        end else if (in_acc) begin
            r_w <= w_clamp[WIN_W-1:0];
            // divisor starts from the prior weight at the very first coefficient
            if (r_frames_seen == '0 && r_coeff_pos == '0) begin
                r_divisor <= DEN_BITS'(r_prior_frames) + DEN_BITS'(1);
            end
        end else if (out_load) begin
            if (last_c) begin
                if (r_frames_seen < r_w && r_filled != '1) begin
                    r_filled <= r_filled + 1'b1;
                end
                if (CMP_W'(r_divisor) < CMP_W'(r_w)) begin
                    r_divisor <= r_divisor + 1'b1;
                end
                if (r_frames_seen < WIN_W'(MAX_WINDOW)) begin
                    r_frames_seen <= r_frames_seen + 1'b1;
                end
                if (r_ring_slot == SLOT_W'(MAX_WINDOW - 1)) r_ring_slot <= '0;
                else                                          r_ring_slot <= r_ring_slot + 1'b1;
                r_coeff_pos <= '0;
            end else begin
                r_coeff_pos <= r_coeff_pos + 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // datapath
    // ---------------------------------------------------------------
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic [SLOT_W-1:0]             r_old_slot;
    logic [PF_BITS-1:0]            r_g;
    logic                          r_use_old;   // window full: subtract leaving frame
    logic                          r_prior_on;  // still blending the prior mean
    logic [ADDR_W-1:0]             r_rd_addr;
    logic [ADDR_W-1:0]             r_wr_addr;
    logic signed [STAT_BITS-1:0]   r_prod;
    logic signed [SUM_BITS-1:0]    r_sum;
    logic signed [STAT_BITS-1:0]   r_stat;
    logic                          r_neg;
    logic [NUM_BITS-1:0]           num_c;

    logic [OS_W-1:0]               old_slot_c;
    logic [CMP_W-1:0]              gap_c;
    logic signed [SUM_BITS:0]      prod_c;
    logic signed [SAMPLE_BITS-1:0] hist_q;
    logic signed [SUM_BITS-1:0]    sum_c;
    logic [NUM_BITS-1:0]           quo;
    logic signed [YW-1:0]          y_c;
    logic signed [YW-1:0]          x_y;
    logic signed [YW-1:0]          q_y;

    logic signed [SUM_BITS-1:0]    r_wsum [DIM];

    assign old_slot_c = (OS_W'(r_ring_slot) >= OS_W'(r_w)) ?
                        OS_W'(r_ring_slot) - OS_W'(r_w) :
                        OS_W'(r_ring_slot) + OS_W'(MAX_WINDOW) - OS_W'(r_w);
    assign gap_c      = CMP_W'(r_w) - CMP_W'(r_filled);
    assign prod_c     = $signed({1'b0, r_g}) * prior_mean(r_coeff_pos);
    assign sum_c      = r_wsum[r_coeff_pos] + SUM_BITS'(r_x)
                        - (r_use_old ? SUM_BITS'(hist_q) : SUM_BITS'(0));

    // |stat| + d/2 in one add: ~stat + 1 for negatives
    assign num_c = r_stat[STAT_BITS-1] ?
                   (~NUM_BITS'(r_stat)) + NUM_BITS'(r_divisor[DEN_BITS-1:1]) + NUM_BITS'(1) :
                   NUM_BITS'(r_stat) + NUM_BITS'(r_divisor[DEN_BITS-1:1]);

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (in_acc) r_x <= i_sample_value;
            end
            ST_SLOT: begin
                r_old_slot <= old_slot_c[SLOT_W-1:0];
                r_use_old  <= !(r_frames_seen < r_w);
                r_prior_on <= CMP_W'(r_filled) < CMP_W'(r_w);
                r_g        <= (gap_c > CMP_W'(r_prior_frames)) ? r_prior_frames
                                                                : gap_c[PF_BITS-1:0];
            end
            ST_ADDR: begin
                r_rd_addr <= ADDR_W'(r_old_slot) * ADDR_W'(DIM) + ADDR_W'(r_coeff_pos);
                r_wr_addr <= ADDR_W'(r_ring_slot) * ADDR_W'(DIM) + ADDR_W'(r_coeff_pos);
                r_prod    <= STAT_BITS'(prod_c);
            end
            ST_SUM: begin
                r_sum <= sum_c;
            end
            ST_STAT: begin
                r_stat <= r_prior_on ? STAT_BITS'(r_sum) + r_prod : STAT_BITS'(r_sum);
            end
            ST_NUM: begin
                r_neg <= r_stat[STAT_BITS-1];
            end
            default: ;
        endcase
    end

    // window sums, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIM; i++) r_wsum[i] <= '0;
        end else if (r_state == ST_SUM) begin
            r_wsum[r_coeff_pos] <= sum_c;
        end
    end

    slwmn_hist_ram #(
        .DATA_W (SAMPLE_BITS),
        .DEPTH  (MAX_WINDOW * DIM),
        .ADDR_W (ADDR_W)
    ) u_hist (
        .i_clk   (i_clk),
        .i_en    (mem_en),
        .i_waddr (r_wr_addr),
        .i_wdata (r_x),
        .i_raddr (r_rd_addr),
        .o_rdata (hist_q)
    );

    // dividend formed straight from the statistic, taken with the start strobe
    assign div_req.start = (r_state == ST_NUM);
    assign div_req.num   = num_c;
    assign div_req.den   = r_divisor;

    slwmn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quo   (quo)
    );

    // ---------------------------------------------------------------
    // output word
    // ---------------------------------------------------------------
    assign x_y = YW'(r_x);
    assign q_y = $signed({2'b00, quo});
    assign y_c = r_neg ? x_y + q_y : x_y - q_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (out_load) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_frame_end <= last_c;
            if (y_c > Y_MAX)      o_norm_value <= Y_MAX[SAMPLE_BITS-1:0];
            else if (y_c < Y_MIN) o_norm_value <= Y_MIN[SAMPLE_BITS-1:0];
            else                  o_norm_value <= y_c[SAMPLE_BITS-1:0];
        end
    end

endmodule
